### rtl/ugns_pkg.sv
package ugns_pkg;

	localparam int MAX_POINTS  = 1024;
	localparam int MAX_RESULTS = 64;
	localparam int DIMENSIONS  = 3;

	localparam int PIDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W  = $clog2(MAX_POINTS + 1);
	localparam int RES_W  = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
	localparam int NRES_W = $clog2(MAX_RESULTS + 1);

	localparam int COORD_W = 32;
	localparam int CSIZE_W = 31;
	localparam int OIDX_W  = 10;

	typedef enum logic [1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_QUERY  = 2'd2,
		ACT_NOP    = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_NEIGHBOR = 3'd0,
		ST_NONE     = 3'd1,
		ST_INSERTED = 3'd2,
		ST_DROPPED  = 3'd3,
		ST_CLEARED  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_DIV,
		S_DIVW,
		S_SCAN,
		S_RESP,
		S_ORD,
		S_OLD
	} state_t;

	typedef struct packed {
		logic    accept;
		logic    div_start;
		logic [1:0] div_sel;
		logic    scan_init;
		logic    scan_run;
		logic    rd_init;
		logic    rd_issue;
		logic    out_load;
		logic    out_sel_buf;
		status_t resp_status;
		logic    clr;
		logic    ins;
	} cmd_t;

	typedef struct packed {
		logic    out_free;
		logic    div_done;
		logic    full;
		logic    scan_done;
		logic    n_zero;
		logic    rd_last;
		action_t action;
	} sts_t;

endpackage

### rtl/ugns_qdiv.sv
// Floor division of a signed coordinate by an unsigned cell size, one bit a cycle.
module ugns_qdiv (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [ugns_pkg::COORD_W-1:0]      dividend,
	input  logic [ugns_pkg::CSIZE_W-1:0]      divisor,
	output logic                              done,
	output logic [ugns_pkg::COORD_W-1:0]      quot
);

	logic                             run_q;
	logic [5:0]                       cnt_q;
	logic                             neg_q;
	logic [ugns_pkg::COORD_W-1:0]     mag_q;
	logic [ugns_pkg::CSIZE_W-1:0]     rem_q;
	logic [ugns_pkg::CSIZE_W-1:0]     div_q;
	logic                             done_q;
	logic [ugns_pkg::COORD_W-1:0]     quot_q;
	logic [ugns_pkg::CSIZE_W:0]       rem_sh;
	logic [ugns_pkg::CSIZE_W:0]       rem_sub;
	logic                             ge;

	assign rem_sh  = {rem_q, mag_q[ugns_pkg::COORD_W-1]};
	assign rem_sub = rem_sh - {1'b0, div_q};
	assign ge      = rem_sh >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 6'd32;
			end else if (run_q) begin
				if (cnt_q != 6'd0) begin
					cnt_q <= cnt_q - 6'd1;
				end else begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[ugns_pkg::COORD_W-1];
			mag_q <= dividend[ugns_pkg::COORD_W-1] ? (~dividend + 32'd1) : dividend;
			rem_q <= '0;
			div_q <= (divisor == '0) ? 31'd1 : divisor;
		end else if (run_q) begin
			if (cnt_q != 6'd0) begin
				mag_q <= {mag_q[ugns_pkg::COORD_W-2:0], ge};
				rem_q <= ge ? rem_sub[ugns_pkg::CSIZE_W-1:0] : rem_sh[ugns_pkg::CSIZE_W-1:0];
			end else begin
				// negative with remainder rounds one further down
				quot_q <= neg_q ? (~mag_q + 32'd1 - {31'd0, (rem_q != '0)}) : mag_q;
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

### rtl/ugns_datapath.sv
module ugns_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ugns_pkg::cmd_t                    cmd,
	output ugns_pkg::sts_t                    sts,
	input  logic                              cfg_wr_en,
	input  logic [ugns_pkg::CSIZE_W-1:0]      cfg_wr_data,
	input  logic [1:0]                        action,
	input  logic [ugns_pkg::COORD_W-1:0]      coord_x,
	input  logic [ugns_pkg::COORD_W-1:0]      coord_y,
	input  logic [ugns_pkg::COORD_W-1:0]      coord_z,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [2:0]                        status,
	output logic [ugns_pkg::OIDX_W-1:0]       point_index,
	output logic                              last,
	output logic                              truncated
);

	localparam int CW = ugns_pkg::COORD_W;

	logic [ugns_pkg::CSIZE_W-1:0]   cell_size_q;
	ugns_pkg::action_t              act_q;
	logic [CW-1:0]                  in_q [3];
	logic [CW-1:0]                  cq_q [3];
	logic                           div_done;
	logic [CW-1:0]                  div_quot;

	logic [ugns_pkg::CNT_W-1:0]     count_q;
	logic [3*CW-1:0]                store_mem [ugns_pkg::MAX_POINTS];
	logic [3*CW-1:0]                store_rd_s1;
	logic [ugns_pkg::PIDX_W-1:0]    p_q;
	logic [ugns_pkg::PIDX_W-1:0]    p_s1;
	logic [1:0]                     off_q [3];
	logic [1:0]                     off_s1 [3];
	logic                           scan_busy_q;
	logic                           vld_s1;
	logic                           p_end;
	logic                           match;
	logic [CW:0]                    diff [3];

	logic [ugns_pkg::NRES_W-1:0]    n_q;
	logic                           cut_q;
	logic [ugns_pkg::PIDX_W-1:0]    res_mem [ugns_pkg::MAX_RESULTS];
	logic [ugns_pkg::PIDX_W-1:0]    res_rd_q;
	logic [ugns_pkg::NRES_W-1:0]    ridx_q;

	logic                           out_valid_q;
	logic [2:0]                     status_q;
	logic [ugns_pkg::OIDX_W-1:0]    pidx_q;
	logic                           last_q;
	logic                           trunc_q;
	logic [31:0]                    idx_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_size_q <= 31'd65536;
		end else if (cfg_wr_en) begin
			cell_size_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			act_q    <= ugns_pkg::action_t'(action);
			in_q[0]  <= coord_x;
			in_q[1]  <= coord_y;
			in_q[2]  <= coord_z;
		end
		if (div_done) begin
			cq_q[cmd.div_sel] <= div_quot;
		end
	end

	ugns_qdiv u_qdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (in_q[cmd.div_sel]),
		.divisor  (cell_size_q),
		.done     (div_done),
		.quot     (div_quot)
	);

	// point store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.clr) begin
			count_q <= '0;
		end else if (cmd.ins) begin
			count_q <= count_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			store_mem[count_q[ugns_pkg::PIDX_W-1:0]] <= {cq_q[0], cq_q[1], cq_q[2]};
		end
		if (cmd.scan_run && scan_busy_q) begin
			store_rd_s1 <= store_mem[p_q];
		end
	end

	// scan: offsets in x, y, z order, every stored point per neighbour cell
	assign p_end = ({1'b0, p_q} == (count_q - 1'b1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_busy_q <= 1'b0;
			vld_s1      <= 1'b0;
		end else begin
			vld_s1 <= cmd.scan_run && scan_busy_q;
			if (cmd.scan_init) begin
				scan_busy_q <= (count_q != '0);
			end else if (cmd.scan_run && scan_busy_q && p_end &&
			             off_q[0] == 2'd2 && off_q[1] == 2'd2 && off_q[2] == 2'd2) begin
				scan_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			p_q    <= '0;
			off_q[0] <= 2'd0;
			off_q[1] <= 2'd0;
			off_q[2] <= 2'd0;
		end else if (cmd.scan_run && scan_busy_q) begin
			p_s1      <= p_q;
			off_s1[0] <= off_q[0];
			off_s1[1] <= off_q[1];
			off_s1[2] <= off_q[2];
			if (p_end) begin
				p_q <= '0;
				if (off_q[2] != 2'd2) begin
					off_q[2] <= off_q[2] + 2'd1;
				end else begin
					off_q[2] <= 2'd0;
					if (off_q[1] != 2'd2) begin
						off_q[1] <= off_q[1] + 2'd1;
					end else begin
						off_q[1] <= 2'd0;
						off_q[0] <= off_q[0] + 2'd1;
					end
				end
			end else begin
				p_q <= p_q + 1'b1;
			end
		end
	end

	always_comb begin
		for (int d = 0; d < 3; d++) begin
			diff[d] = {store_rd_s1[(2-d)*CW+CW-1], store_rd_s1[(2-d)*CW +: CW]}
			        - {cq_q[d][CW-1], cq_q[d]};
		end
		// stored - centre equals offset - 1, no wrap
		match = vld_s1;
		for (int d = 0; d < 3; d++) begin
			match = match && ((diff[d] + 33'd1) == {31'd0, off_s1[d]});
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			n_q   <= '0;
			cut_q <= 1'b0;
		end else if (match) begin
			if (n_q < ugns_pkg::NRES_W'(ugns_pkg::MAX_RESULTS)) begin
				res_mem[n_q[ugns_pkg::RES_W-1:0]] <= p_s1;
				n_q <= n_q + 1'b1;
			end else begin
				cut_q <= 1'b1;
			end
		end
		if (cmd.rd_init) begin
			ridx_q <= '0;
		end else if (cmd.out_load && cmd.out_sel_buf) begin
			ridx_q <= ridx_q + 1'b1;
		end
		if (cmd.rd_issue) begin
			res_rd_q <= res_mem[ridx_q[ugns_pkg::RES_W-1:0]];
		end
	end

	// output register
	always_comb begin
		if (cmd.out_sel_buf) begin
			idx_ext = 32'(res_rd_q);
		end else if (cmd.resp_status == ugns_pkg::ST_INSERTED) begin
			idx_ext = 32'(count_q);
		end else begin
			idx_ext = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			pidx_q <= idx_ext[ugns_pkg::OIDX_W-1:0];
			if (cmd.out_sel_buf) begin
				status_q <= ugns_pkg::ST_NEIGHBOR;
				last_q   <= (ridx_q == n_q - 1'b1);
				trunc_q  <= cut_q;
			end else begin
				status_q <= cmd.resp_status;
				last_q   <= 1'b1;
				trunc_q  <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign point_index = pidx_q;
	assign last        = last_q;
	assign truncated   = trunc_q;

	assign sts.out_free  = !out_valid_q || !out_stall;
	assign sts.div_done  = div_done;
	assign sts.full      = (count_q == ugns_pkg::CNT_W'(ugns_pkg::MAX_POINTS));
	assign sts.scan_done = !scan_busy_q && !vld_s1;
	assign sts.n_zero    = (n_q == '0);
	assign sts.rd_last   = (ridx_q == n_q - 1'b1);
	assign sts.action    = act_q;

	a_nres: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> n_q <= ugns_pkg::NRES_W'(ugns_pkg::MAX_RESULTS))
		else $error("result count beyond limit");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ugns_pkg::CNT_W'(ugns_pkg::MAX_POINTS))
		else $error("point count beyond store depth");
	a_noovw: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("output overwritten while stalled");
	a_insfull: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |-> !sts.full)
		else $error("insert into full store");

endmodule

### rtl/ugns_ctrl.sv
module ugns_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  ugns_pkg::sts_t    sts,
	output ugns_pkg::cmd_t    cmd
);

	ugns_pkg::state_t state_q;
	ugns_pkg::state_t state_d;
	logic [1:0]       sel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ugns_pkg::S_IDLE;
			sel_q   <= 2'd0;
		end else begin
			state_q <= state_d;
			if (state_q == ugns_pkg::S_DECODE) begin
				sel_q <= 2'd0;
			end else if (state_q == ugns_pkg::S_DIVW && sts.div_done) begin
				sel_q <= sel_q + 2'd1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ugns_pkg::S_IDLE: begin
				if (in_valid) state_d = ugns_pkg::S_DECODE;
			end
			ugns_pkg::S_DECODE: begin
				unique case (sts.action)
					ugns_pkg::ACT_CLEAR:  state_d = ugns_pkg::S_RESP;
					ugns_pkg::ACT_INSERT: state_d = ugns_pkg::S_DIV;
					ugns_pkg::ACT_QUERY:  state_d = ugns_pkg::S_DIV;
					ugns_pkg::ACT_NOP:    state_d = ugns_pkg::S_IDLE;
				endcase
			end
			ugns_pkg::S_DIV: state_d = ugns_pkg::S_DIVW;
			ugns_pkg::S_DIVW: begin
				if (sts.div_done) begin
					if (sel_q != 2'd2)                           state_d = ugns_pkg::S_DIV;
					else if (sts.action == ugns_pkg::ACT_QUERY)  state_d = ugns_pkg::S_SCAN;
					else                                         state_d = ugns_pkg::S_RESP;
				end
			end
			ugns_pkg::S_SCAN: begin
				if (sts.scan_done) state_d = sts.n_zero ? ugns_pkg::S_RESP : ugns_pkg::S_ORD;
			end
			ugns_pkg::S_RESP: begin
				if (sts.out_free) state_d = ugns_pkg::S_IDLE;
			end
			ugns_pkg::S_ORD: state_d = ugns_pkg::S_OLD;
			ugns_pkg::S_OLD: begin
				if (sts.out_free) state_d = sts.rd_last ? ugns_pkg::S_IDLE : ugns_pkg::S_ORD;
			end
			default: state_d = ugns_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd             = '0;
		cmd.div_sel     = sel_q;
		cmd.resp_status = ugns_pkg::ST_NONE;
		in_stall        = (state_q != ugns_pkg::S_IDLE);
		unique case (state_q)
			ugns_pkg::S_IDLE:   cmd.accept = in_valid;
			ugns_pkg::S_DECODE: ;
			ugns_pkg::S_DIV:    cmd.div_start = 1'b1;
			ugns_pkg::S_DIVW: begin
				cmd.scan_init = sts.div_done && sel_q == 2'd2;
			end
			ugns_pkg::S_SCAN: begin
				cmd.scan_run = 1'b1;
				cmd.rd_init  = sts.scan_done;
			end
			ugns_pkg::S_RESP: begin
				priority case (sts.action)
					ugns_pkg::ACT_CLEAR:  cmd.resp_status = ugns_pkg::ST_CLEARED;
					ugns_pkg::ACT_INSERT: cmd.resp_status = sts.full ? ugns_pkg::ST_DROPPED
					                                               : ugns_pkg::ST_INSERTED;
					default:              cmd.resp_status = ugns_pkg::ST_NONE;
				endcase
				cmd.out_load = sts.out_free;
				cmd.clr = sts.out_free && sts.action == ugns_pkg::ACT_CLEAR;
				cmd.ins = sts.out_free && sts.action == ugns_pkg::ACT_INSERT && !sts.full;
			end
			ugns_pkg::S_ORD: cmd.rd_issue = 1'b1;
			ugns_pkg::S_OLD: begin
				cmd.out_load    = sts.out_free;
				cmd.out_sel_buf = 1'b1;
			end
			default: ;
		endcase
	end

endmodule

### rtl/uniform_grid_neighbor_search.sv
// Grid neighbour search: clear, insert, query and no-op transactions, one at a time. Coordinates
// are mapped to cells by floor division by cell_size in a serial divider, one axis after another
// for an insert or query. A query then reads every stored point once for each of the 27
// neighbour cells through the single store read port, then emits its buffered results.
// Clear and insert give one result each; a no-op gives none. Up to 64 neighbours are buffered;
// more set truncated on every result of that query. The user must write cell_size only while
// idle; the block does not enforce it. A value of 0 acts as 1.
module uniform_grid_neighbor_search (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [ugns_pkg::CSIZE_W-1:0]      cfg_wr_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        action,
	input  logic [ugns_pkg::COORD_W-1:0]      coord_x,
	input  logic [ugns_pkg::COORD_W-1:0]      coord_y,
	input  logic [ugns_pkg::COORD_W-1:0]      coord_z,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [2:0]                        status,
	output logic [ugns_pkg::OIDX_W-1:0]       point_index,
	output logic                              last,
	output logic                              truncated
);

	ugns_pkg::cmd_t cmd;
	ugns_pkg::sts_t sts;

	ugns_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	ugns_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.action      (action),
		.coord_x     (coord_x),
		.coord_y     (coord_y),
		.coord_z     (coord_z),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.point_index (point_index),
		.last        (last),
		.truncated   (truncated)
	);

endmodule

### tb/sv/tb_uniform_grid_neighbor_search.sv
module tb_uniform_grid_neighbor_search;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		ugns_pkg::status_t st;
		logic [9:0]        idx;
		logic              lst;
		logic              trunc;
	} grid_result_t;

	class grid_scoreboard;
		logic [30:0]  cell_size;
		int unsigned  point_count;
		int           cell_xs[ugns_pkg::MAX_POINTS];
		int           cell_ys[ugns_pkg::MAX_POINTS];
		int           cell_zs[ugns_pkg::MAX_POINTS];
		grid_result_t awaited[$];
		int           errors;

		function new();
			cell_size = 31'd65536;
			point_count = 0;
			errors = 0;
		endfunction

		function int to_cell(logic [31:0] raw);
			longint v;
			longint h;
			longint q;
			v = longint'($signed(raw));
			h = (cell_size == 0) ? 64'sd1 : longint'({33'd0, cell_size});
			q = v / h;
			if ((v % h) != 0 && v < 0)
				q = q - 1;
			return int'(q);
		endfunction

		function void push(ugns_pkg::status_t st, int unsigned idx, bit lst, bit trunc);
			grid_result_t r;
			r.st = st;
			r.idx = idx[9:0];
			r.lst = lst;
			r.trunc = trunc;
			awaited = {awaited, r};
		endfunction

		function void note_input(logic [1:0] act, logic [31:0] x, logic [31:0] y,
				logic [31:0] z);
			int cx;
			int cy;
			int cz;
			int unsigned hits[$];
			bit cut;
			cx = to_cell(x);
			cy = to_cell(y);
			cz = to_cell(z);
			cut = 0;
			case (ugns_pkg::action_t'(act))
				ugns_pkg::ACT_CLEAR: begin
					point_count = 0;
					push(ugns_pkg::ST_CLEARED, 0, 1, 0);
				end
				ugns_pkg::ACT_INSERT: begin
					if (point_count >= ugns_pkg::MAX_POINTS) begin
						push(ugns_pkg::ST_DROPPED, 0, 1, 0);
					end else begin
						cell_xs[point_count] = cx;
						cell_ys[point_count] = cy;
						cell_zs[point_count] = cz;
						push(ugns_pkg::ST_INSERTED, point_count, 1, 0);
						point_count++;
					end
				end
				ugns_pkg::ACT_QUERY: begin
					// bounds in 64 bits so cells past the edge of the range match nothing
					for (longint a = longint'(cx) - 1; a <= longint'(cx) + 1; a++)
						for (longint b = longint'(cy) - 1; b <= longint'(cy) + 1; b++)
							for (longint c = longint'(cz) - 1; c <= longint'(cz) + 1; c++)
								for (int unsigned p = 0; p < point_count; p++)
									if (longint'(cell_xs[p]) == a && longint'(cell_ys[p]) == b
											&& longint'(cell_zs[p]) == c) begin
										if (hits.size() < ugns_pkg::MAX_RESULTS)
											hits = {hits, p};
										else
											cut = 1;
									end
					if (hits.size() == 0) begin
						push(ugns_pkg::ST_NONE, 0, 1, 0);
					end else begin
						foreach (hits[r])
							push(ugns_pkg::ST_NEIGHBOR, hits[r], r == hits.size() - 1, cut);
					end
				end
				default: ;
			endcase
		endfunction

		function void check_result(logic [2:0] st, logic [9:0] idx, logic lst, logic trunc);
			grid_result_t e;
			if (awaited.size() == 0) begin
				$error("result with nothing awaited: status %0d index %0d", st, idx);
				errors++;
				return;
			end
			e = awaited.pop_front();
			if (st !== e.st) begin
				$error("status expected %0d actual %0d", e.st, st);
				errors++;
			end
			if (idx !== e.idx) begin
				$error("point_index expected %0d actual %0d", e.idx, idx);
				errors++;
			end
			if (lst !== e.lst) begin
				$error("last expected %0d actual %0d", e.lst, lst);
				errors++;
			end
			if (trunc !== e.trunc) begin
				$error("truncated expected %0d actual %0d", e.trunc, trunc);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [30:0] cfg_wr_data;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  action;
	logic [31:0] coord_x;
	logic [31:0] coord_y;
	logic [31:0] coord_z;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  status;
	logic [9:0]  point_index;
	logic        last;
	logic        truncated;

	grid_scoreboard sb = new();
	int send_idle_pct;
	int stall_pct;
	logic [31:0] centre_x, centre_y, centre_z;

	uniform_grid_neighbor_search u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .point_index(point_index), .last(last), .truncated(truncated)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	initial begin
		#40_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
		if (arst_n && out_valid && !out_stall)
			sb.check_result(status, point_index, last, truncated);
	end

	// valid stays high between back-to-back transactions
	task send_item(input logic [1:0] act, input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		action <= act;
		coord_x <= x;
		coord_y <= y;
		coord_z <= z;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_input(act, x, y, z);
	endtask

	task write_cell_size(input logic [30:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.awaited.size() != 0)
			@(posedge clk);
		// a trailing no-op may still be in flight
		repeat (300) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.cell_size = v;
	endtask

	function logic [31:0] near_centre(logic [31:0] c);
		longint span;
		longint off;
		span = (sb.cell_size == 0) ? 64'd1 : longint'({33'd0, sb.cell_size});
		off = longint'({32'd0, $urandom}) % (6 * span + 1) - 3 * span;
		return c + off[31:0];
	endfunction

	task random_phase(input int n);
		int roll;
		logic [1:0] act;
		for (int i = 0; i < n; i++) begin
			roll = $urandom_range(99);
			if (sb.point_count > 70 || roll < 5)
				act = ugns_pkg::ACT_CLEAR;
			else if (roll < 8)
				act = ugns_pkg::ACT_NOP;
			else if (roll < 55)
				act = ugns_pkg::ACT_INSERT;
			else
				act = ugns_pkg::ACT_QUERY;
			if ($urandom_range(99) < 15)
				send_item(act, $urandom, $urandom, $urandom);
			else
				send_item(act, near_centre(centre_x), near_centre(centre_y),
					near_centre(centre_z));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		in_valid = 1'b0;
		action = ugns_pkg::ACT_NOP;
		coord_x = '0;
		coord_y = '0;
		coord_z = '0;
		out_stall = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset cell size, empty store, no-op, signs and extremes
		send_item(ugns_pkg::ACT_QUERY, 32'd0, 32'd0, 32'd0);
		send_item(ugns_pkg::ACT_NOP, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send_item(ugns_pkg::ACT_INSERT, 32'h0001_8000, 32'hFFFF_8000, 32'd0);
		send_item(ugns_pkg::ACT_INSERT, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'h0001_0000);
		send_item(ugns_pkg::ACT_INSERT, 32'h0004_0000, 32'd0, 32'd0);
		send_item(ugns_pkg::ACT_QUERY, 32'd0, 32'd0, 32'd0);
		send_item(ugns_pkg::ACT_QUERY, 32'h0003_0000, 32'd0, 32'd0);
		send_item(ugns_pkg::ACT_CLEAR, 32'd0, 32'd0, 32'd0);
		send_item(ugns_pkg::ACT_QUERY, 32'd0, 32'd0, 32'd0);
		write_cell_size(31'd0);
		send_item(ugns_pkg::ACT_INSERT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_item(ugns_pkg::ACT_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_item(ugns_pkg::ACT_INSERT, 32'h8000_0001, 32'h7FFF_FFFE, 32'h8000_0000);
		send_item(ugns_pkg::ACT_QUERY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_item(ugns_pkg::ACT_QUERY, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_item(ugns_pkg::ACT_QUERY, 32'h8000_0001, 32'h7FFF_FFFF, 32'h8000_0001);
		write_cell_size(31'h7FFF_FFFF);
		send_item(ugns_pkg::ACT_QUERY, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
		send_item(ugns_pkg::ACT_INSERT, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
		send_item(ugns_pkg::ACT_QUERY, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 88; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 88; end
				default: begin send_idle_pct = 18; stall_pct = 18; end
			endcase
			case (ph)
				0: write_cell_size(31'd1);
				1: write_cell_size(31'h7FFF_FFFF);
				2: write_cell_size($urandom_range(1, 31'h7FFF_FFFF));
				default: write_cell_size($urandom_range(1, 1 << 20));
			endcase
			centre_x = $urandom;
			centre_y = $urandom;
			centre_z = $urandom;
			random_phase(8);
		end

		// more points in one cell than the result limit, then a truncated query
		send_idle_pct = 0;
		stall_pct = 0;
		write_cell_size(31'd65536);
		send_item(ugns_pkg::ACT_CLEAR, 32'd0, 32'd0, 32'd0);
		for (int i = 0; i <= ugns_pkg::MAX_RESULTS; i++)
			send_item(ugns_pkg::ACT_INSERT, $urandom_range(0, 32'hFFFF),
				$urandom_range(0, 32'hFFFF), 32'd0);
		stall_pct = 18;
		send_item(ugns_pkg::ACT_QUERY, 32'd0, 32'd0, 32'd0);
		send_item(ugns_pkg::ACT_QUERY, 32'h0010_0000, 32'd0, 32'd0);
		send_item(ugns_pkg::ACT_CLEAR, 32'd0, 32'd0, 32'd0);

		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (sb.errors == 0 && sb.awaited.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
